@@ sv/blm_pkg.sv @@
// ----------------------------------------------------------------------------
// Boundary list allocator package
// Shared widths, codes and beat types of the boundary list allocator.
// ----------------------------------------------------------------------------
package blm_pkg;

	localparam int MAX_BOUNDS  = 64;
	localparam int IDX_W       = $clog2(MAX_BOUNDS);
	localparam int CNT_W       = IDX_W + 1;
	localparam int OFFSET_BITS = 20;
	localparam int POS_W       = 21;

	localparam logic [POS_W-1:0] CAP_RESET = POS_W'(65536);
	localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_BOUNDS);

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_SPACE  = 2'd1,
		ST_BAD_FREE  = 2'd2,
		ST_LIST_FULL = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_INIT0,
		S_INIT1,
		S_IDLE,
		S_A_SCAN,
		S_F_SCAN,
		S_F_DECIDE,
		S_DROP,
		S_ADD,
		S_ADD_FILL0,
		S_ADD_FILL1,
		S_RESP
	} state_t;

	// One boundary: the start of a region and whether that region is used.
	typedef struct packed {
		logic             used;
		logic [POS_W-1:0] pos;
	} bound_t;

	localparam int BOUND_W = $bits(bound_t);

	typedef struct packed {
		op_t                    op;
		logic [OFFSET_BITS-1:0] offset;
		logic [POS_W-1:0]       size;
	} req_t;

	typedef struct packed {
		logic [OFFSET_BITS-1:0] offset_out;
		status_t                status;
	} rsp_t;

	// Finished result handed from the sequencer to the output register.
	typedef struct packed {
		logic load;
		rsp_t rsp;
	} res_t;

	// Access to the boundary memory for one cycle.
	typedef struct packed {
		logic               rd_en;
		logic [IDX_W-1:0]   rd_addr;
		logic               wr_en;
		logic [IDX_W-1:0]   wr_addr;
		logic [BOUND_W-1:0] wr_data;
	} mem_req_t;

endpackage

@@ sv/blm_ram.sv @@
// ----------------------------------------------------------------------------
// Boundary list allocator RAM
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module blm_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 22,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ sv/blm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Boundary list allocator sequencer
// Scans, edits and shifts the boundary list held in the boundary memory.
// ----------------------------------------------------------------------------
module blm_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_fire,
	input  blm_pkg::req_t                req,
	output logic                         idle,
	input  logic [blm_pkg::POS_W-1:0]    capacity,
	input  logic                         slot_free,
	output blm_pkg::res_t                res,
	output blm_pkg::mem_req_t            mreq,
	input  logic [blm_pkg::BOUND_W-1:0]  rd_data
);

	localparam int CW = blm_pkg::CNT_W;
	localparam int PW = blm_pkg::POS_W;

	blm_pkg::state_t state_q, state_d;

	// Request and list registers.
	logic [blm_pkg::OFFSET_BITS-1:0] p_q;
	logic [PW-1:0]                   size_q;
	logic [CW-1:0]                   cnt_q;
	logic                            clr_q;

	// Read issue pointer and the index of the entry whose data returns.
	logic [CW-1:0] ptr_q;
	logic          more_q;
	logic          dv_s1;
	logic [CW-1:0] di_s1;

	// Scan results.
	logic [PW-1:0]   end_q;
	logic [CW-1:0]   k_q;
	logic [PW-1:0]   a_q;
	logic            usedk_q;
	logic [PW-1:0]   b_q;
	logic            bused_q;
	logic            bv_q;
	logic [CW-1:0]   lim_q;
	blm_pkg::rsp_t   rsp_q;

	blm_pkg::bound_t ent;
	logic [PW-1:0]   newpos;
	logic            fits;
	logic            drop_a;
	logic            last_up;
	logic [PW:0]     e_sum;
	logic            bad;
	logic            pa;
	logic            eb;
	logic            full;
	logic            rd_en;

	// Evaluation of the returning entry.
	always_comb begin
		ent     = blm_pkg::bound_t'(rd_data);
		newpos  = ent.pos + size_q;
		if (end_q <= ent.pos) begin
			fits = !ent.used && (size_q == '0);
		end else begin
			fits = !ent.used && ((end_q - ent.pos) >= size_q);
		end
		drop_a  = ((di_s1 + CW'(1)) < cnt_q) && (di_s1 != '0) && (newpos == end_q);
		last_up = (di_s1 == lim_q);
		e_sum   = {2'b00, p_q} + {1'b0, size_q};
		bad     = !usedk_q || !bv_q || ({1'b0, p_q} >= b_q) || (e_sum > {1'b0, b_q});
		pa      = ({1'b0, p_q} == a_q);
		eb      = (e_sum == {1'b0, b_q});
		full    = (cnt_q + CW'(2)) > blm_pkg::CNT_MAX;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			blm_pkg::S_INIT0: state_d = blm_pkg::S_INIT1;
			blm_pkg::S_INIT1: state_d = clr_q ? blm_pkg::S_RESP : blm_pkg::S_IDLE;
			blm_pkg::S_IDLE: begin
				if (req_fire) begin
					priority case (req.op)
						blm_pkg::OP_ALLOC: state_d = blm_pkg::S_A_SCAN;
						blm_pkg::OP_FREE:  state_d = blm_pkg::S_F_SCAN;
						blm_pkg::OP_CLEAR: state_d = blm_pkg::S_INIT0;
						default:           state_d = blm_pkg::S_RESP;
					endcase
				end
			end
			blm_pkg::S_A_SCAN: begin
				if (dv_s1) begin
					if (fits) begin
						state_d = (drop_a && (di_s1 + CW'(3) <= cnt_q)) ?
							blm_pkg::S_DROP : blm_pkg::S_RESP;
					end else if (di_s1 == '0) begin
						state_d = blm_pkg::S_RESP;
					end
				end
			end
			blm_pkg::S_F_SCAN: begin
				if (dv_s1 && last_up) begin
					state_d = blm_pkg::S_F_DECIDE;
				end
			end
			blm_pkg::S_F_DECIDE: begin
				if (bad || size_q == '0) begin
					state_d = blm_pkg::S_RESP;
				end else if (pa && eb) begin
					state_d = (k_q != '0 && (k_q + CW'(3) <= cnt_q)) ?
						blm_pkg::S_DROP : blm_pkg::S_RESP;
				end else if ((pa && k_q != '0) || eb || full) begin
					state_d = blm_pkg::S_RESP;
				end else begin
					state_d = blm_pkg::S_ADD;
				end
			end
			blm_pkg::S_DROP: begin
				if (dv_s1 && last_up) begin
					state_d = blm_pkg::S_RESP;
				end
			end
			blm_pkg::S_ADD: begin
				if (dv_s1 && last_up) begin
					state_d = blm_pkg::S_ADD_FILL0;
				end
			end
			blm_pkg::S_ADD_FILL0: state_d = blm_pkg::S_ADD_FILL1;
			blm_pkg::S_ADD_FILL1: state_d = blm_pkg::S_RESP;
			blm_pkg::S_RESP: begin
				if (slot_free) begin
					state_d = blm_pkg::S_IDLE;
				end
			end
			default: state_d = blm_pkg::S_IDLE;
		endcase
	end

	// Memory accesses and handshake outputs.
	always_comb begin
		blm_pkg::bound_t wb;
		logic [CW-1:0]   wa;
		wb       = '0;
		wa       = '0;
		rd_en    = 1'b0;
		mreq     = '0;
		idle     = (state_q == blm_pkg::S_IDLE);
		res.load = (state_q == blm_pkg::S_RESP) && slot_free;
		res.rsp  = rsp_q;
		unique case (state_q)
			blm_pkg::S_INIT0: begin
				wb.used = 1'b1;
				wa      = '0;
				mreq.wr_en = 1'b1;
			end
			blm_pkg::S_INIT1: begin
				wa         = CW'(1);
				mreq.wr_en = 1'b1;
			end
			blm_pkg::S_A_SCAN: begin
				rd_en = more_q;
				if (dv_s1 && fits) begin
					wb.pos     = newpos;
					wa         = di_s1;
					mreq.wr_en = 1'b1;
				end
			end
			blm_pkg::S_F_SCAN: begin
				rd_en = more_q;
			end
			blm_pkg::S_F_DECIDE: begin
				if (!bad && size_q != '0) begin
					if (pa && eb) begin
						if (k_q == '0) begin
							wb.used    = bused_q;
							wa         = CW'(1);
							mreq.wr_en = 1'b1;
						end
					end else if (pa && k_q != '0) begin
						wb.used    = 1'b1;
						wb.pos     = e_sum[PW-1:0];
						wa         = k_q;
						mreq.wr_en = 1'b1;
					end else if (eb) begin
						wb.used    = bused_q;
						wb.pos     = {1'b0, p_q};
						wa         = k_q + CW'(1);
						mreq.wr_en = 1'b1;
					end
				end
			end
			blm_pkg::S_DROP: begin
				rd_en = more_q;
				if (dv_s1) begin
					wb         = ent;
					wa         = di_s1 - CW'(2);
					mreq.wr_en = 1'b1;
				end
			end
			blm_pkg::S_ADD: begin
				rd_en = more_q;
				if (dv_s1) begin
					wb         = ent;
					wa         = di_s1 + CW'(2);
					mreq.wr_en = 1'b1;
				end
			end
			blm_pkg::S_ADD_FILL0: begin
				wb.pos     = {1'b0, p_q};
				wa         = k_q + CW'(1);
				mreq.wr_en = 1'b1;
			end
			blm_pkg::S_ADD_FILL1: begin
				wb.used    = 1'b1;
				wb.pos     = e_sum[PW-1:0];
				wa         = k_q + CW'(2);
				mreq.wr_en = 1'b1;
			end
			default: begin
			end
		endcase
		mreq.rd_en   = rd_en;
		mreq.rd_addr = ptr_q[blm_pkg::IDX_W-1:0];
		mreq.wr_addr = wa[blm_pkg::IDX_W-1:0];
		mreq.wr_data = wb;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blm_pkg::S_INIT0;
			cnt_q   <= CW'(2);
			clr_q   <= 1'b0;
			more_q  <= 1'b0;
			dv_s1   <= 1'b0;
			di_s1   <= '0;
			ptr_q   <= '0;
			lim_q   <= '0;
		end else begin
			state_q <= state_d;
			dv_s1   <= rd_en && (state_d == state_q);
			di_s1   <= ptr_q;
			unique case (state_q)
				blm_pkg::S_INIT1: cnt_q <= CW'(2);
				blm_pkg::S_IDLE: begin
					clr_q <= 1'b1;
					if (req_fire && req.op == blm_pkg::OP_FREE) begin
						ptr_q  <= '0;
						lim_q  <= cnt_q - CW'(1);
						more_q <= 1'b1;
					end else begin
						ptr_q  <= cnt_q - CW'(1);
						more_q <= 1'b1;
					end
				end
				blm_pkg::S_A_SCAN: begin
					if (dv_s1 && fits && drop_a && (di_s1 + CW'(3) <= cnt_q)) begin
						ptr_q  <= di_s1 + CW'(2);
						lim_q  <= cnt_q - CW'(1);
						more_q <= 1'b1;
					end else begin
						if (rd_en) begin
							more_q <= (ptr_q != '0);
							ptr_q  <= ptr_q - CW'(1);
						end
						if (dv_s1 && fits && drop_a) begin
							cnt_q <= cnt_q - CW'(2);
						end
					end
				end
				blm_pkg::S_F_SCAN: begin
					if (rd_en) begin
						more_q <= (ptr_q != lim_q);
						ptr_q  <= ptr_q + CW'(1);
					end
				end
				blm_pkg::S_F_DECIDE: begin
					if (!bad && size_q != '0 && pa && eb && k_q != '0) begin
						if (k_q + CW'(3) <= cnt_q) begin
							ptr_q  <= k_q + CW'(2);
							lim_q  <= cnt_q - CW'(1);
							more_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q - CW'(2);
						end
					end else begin
						ptr_q  <= cnt_q - CW'(1);
						lim_q  <= k_q + CW'(1);
						more_q <= 1'b1;
					end
				end
				blm_pkg::S_DROP: begin
					if (rd_en) begin
						more_q <= (ptr_q != lim_q);
						ptr_q  <= ptr_q + CW'(1);
					end
					if (dv_s1 && last_up) begin
						cnt_q <= cnt_q - CW'(2);
					end
				end
				blm_pkg::S_ADD: begin
					if (rd_en) begin
						more_q <= (ptr_q != lim_q);
						ptr_q  <= ptr_q - CW'(1);
					end
				end
				blm_pkg::S_ADD_FILL1: cnt_q <= cnt_q + CW'(2);
				default: begin
				end
			endcase
		end
	end

	// Payload registers: request, scan results and the pending result.
	always_ff @(posedge clk) begin
		unique case (state_q)
			blm_pkg::S_IDLE: begin
				p_q     <= req.offset;
				size_q  <= req.size;
				end_q   <= capacity;
				bv_q    <= 1'b0;
				k_q     <= '0;
				a_q     <= '0;
				usedk_q <= 1'b0;
				rsp_q   <= '0;
			end
			blm_pkg::S_A_SCAN: begin
				if (dv_s1) begin
					if (fits) begin
						rsp_q.offset_out <= ent.pos[blm_pkg::OFFSET_BITS-1:0];
						rsp_q.status     <= blm_pkg::ST_OK;
					end else begin
						end_q <= ent.pos;
						if (di_s1 == '0) begin
							rsp_q.status <= blm_pkg::ST_NO_SPACE;
						end
					end
				end
			end
			blm_pkg::S_F_SCAN: begin
				if (dv_s1) begin
					if (ent.pos <= {1'b0, p_q}) begin
						k_q     <= di_s1;
						a_q     <= ent.pos;
						usedk_q <= ent.used;
						bv_q    <= 1'b0;
					end else if (!bv_q) begin
						b_q     <= ent.pos;
						bused_q <= ent.used;
						bv_q    <= 1'b1;
					end
				end
			end
			blm_pkg::S_F_DECIDE: begin
				if (bad) begin
					rsp_q.status <= blm_pkg::ST_BAD_FREE;
				end else if (size_q != '0 && !(pa && eb) && !(pa && k_q != '0) && !eb
						&& full) begin
					rsp_q.status <= blm_pkg::ST_LIST_FULL;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ sv/boundary_list_allocator.sv @@
// ----------------------------------------------------------------------------
// Boundary list allocator
// Arena allocator over a sorted boundary list, with a registered result port.
// ----------------------------------------------------------------------------
// One request is worked at a time. An allocate reads the boundary list from
// the top down, one entry per cycle through the memory read port, and stops
// at the first free region that fits; a free reads the whole list once. A
// region that is removed or inserted shifts the entries above it by two, one
// entry per cycle. The list holds at most 64 boundaries in use. After reset
// and after a clear, states S_INIT0 and S_INIT1 rebuild the empty list
// before the next request is taken. A result waiting in the output register
// does not stop the next request from being taken.
module boundary_list_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  blm_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output blm_pkg::rsp_t              rsp,
	input  logic                       cfg_we,
	input  logic [blm_pkg::POS_W-1:0]  cfg_data
);

	logic [blm_pkg::POS_W-1:0]   capacity_q;
	logic                        idle;
	logic                        slot_free;
	blm_pkg::res_t               res;
	blm_pkg::mem_req_t           mreq;
	logic [blm_pkg::BOUND_W-1:0] rd_data;

	assign req_stall = !idle;
	assign slot_free = !rsp_valid || !rsp_stall;

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= blm_pkg::CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_data;
		end
	end

	// Output register: loads a result beat when the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (res.load) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			rsp <= res.rsp;
		end
	end

	blm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_fire  (req_valid && !req_stall),
		.req       (req),
		.idle      (idle),
		.capacity  (capacity_q),
		.slot_free (slot_free),
		.res       (res),
		.mreq      (mreq),
		.rd_data   (rd_data)
	);

	blm_ram #(
		.DEPTH (blm_pkg::MAX_BOUNDS),
		.WIDTH (blm_pkg::BOUND_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (mreq.rd_en),
		.rd_addr (mreq.rd_addr),
		.rd_data (rd_data),
		.wr_en   (mreq.wr_en),
		.wr_addr (mreq.wr_addr),
		.wr_data (mreq.wr_data)
	);

endmodule
